FILE: hdl/octave_perlin_noise_2d_core_assert.svh
// Assertion macros for the octave Perlin noise core.
// Depends on signals named clock and reset in the including module.
`ifndef OCTAVE_PERLIN_NOISE_2D_CORE_ASSERT_SVH
`define OCTAVE_PERLIN_NOISE_2D_CORE_ASSERT_SVH

// cause followed by effect a fixed number of cycles later
`define OPN_ASSERT_AFTER(label, cause, n, effect) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |-> ##n (effect)) \
      else $error("latency check failed");

// condition implies consequence in the same cycle
`define OPN_ASSERT_NOW(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("consistency check failed");

`endif

FILE: hdl/opn_pkg.sv
// Shared constants, types and helpers for the octave Perlin noise core.
// No dependencies.
`timescale 1ns / 1ps
package opn_pkg;
   localparam int TABLE_SIZE      = 256;
   localparam int IDX_W           = 8;
   localparam int OCT_SEL_W       = 3;
   localparam int COUNT_W         = 4;
   localparam int OUT_W           = 26;
   localparam int DEF_MAX_OCTAVES = 8;
   localparam int DEF_FRAC_BITS   = 16;
   localparam int LANE_LAT        = 6;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;
   localparam logic [31:0] GRAD_X_BITS = 32'h4655_2222;
   localparam logic [31:0] GRAD_Y_BITS = 32'h2222_550A;
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   typedef struct packed {
      logic                 en;
      logic [OCT_SEL_W-1:0] octave;
      logic [IDX_W-1:0]     addr;
      logic [IDX_W-1:0]     data;
   } tbl_wr_type;

   function automatic logic [1:0] grad_code(input logic [3:0] h, input logic [31:0] bits);
      return bits[{h, 1'b0} +: 2];
   endfunction
endpackage

FILE: hdl/octave_perlin_noise_2d_core.sv
// Top level of the octave Perlin noise core: input register, octave lanes, summation.
// Depends on opn_pkg, opn_lane, opn_sum and the assertion macro header.
//
//  channel  ports                       transfer
//  request  start/busy, req_*           edge with start high and busy low
//  result   rsp_strobe, rsp_noise_sum   one cycle with rsp_strobe high
//  csr      csr_we, csr_wdata           edge with csr_we high
//
// One item enters every cycle; busy stays low. The pipeline is nine registers deep:
// input, three table levels per octave, gradients, two lerps, weighting, sum.
// Each evaluate transfer strobes one result out of the sum register; loads give none.
// Synchronous reset clears valid bits and sets octave_count to 8; tables stay undefined.
// The receiver cannot stall, so nothing ever holds in the pipeline.
`timescale 1ns / 1ps
`include "octave_perlin_noise_2d_core_assert.svh"
module octave_perlin_noise_2d_core #(
   parameter int MAX_OCTAVES = opn_pkg::DEF_MAX_OCTAVES,
   parameter int FRAC_BITS   = opn_pkg::DEF_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_mode,
   input  logic [2:0]                        req_octave_select,
   input  logic [7:0]                        req_table_index,
   input  logic [7:0]                        req_table_value,
   input  logic signed [31:0]                req_x_coord,
   input  logic signed [31:0]                req_y_coord,
   output logic                              rsp_strobe,
   output logic signed [opn_pkg::OUT_W-1:0]  rsp_noise_sum,
   input  logic                              csr_we,
   input  logic [opn_pkg::COUNT_W-1:0]       csr_wdata
);
   logic                      valid_ff, mode_ff;
   opn_pkg::tbl_wr_type       wr;
   logic [2:0]                osel_ff;
   logic [7:0]                idx_ff, val_ff;
   logic signed [31:0]        x_ff, y_ff;
   logic [opn_pkg::COUNT_W-1:0] count_ff;
   logic [opn_pkg::LANE_LAT-1:0] eval_ff;
   logic signed [FRAC_BITS+5:0] noise [MAX_OCTAVES];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         eval_ff  <= '0;
         count_ff <= opn_pkg::COUNT_RESET;
      end else begin
         valid_ff <= start && !busy;
         eval_ff  <= {eval_ff[opn_pkg::LANE_LAT-2:0], valid_ff && (mode_ff == opn_pkg::MODE_EVAL)};
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
      mode_ff <= req_mode;
      osel_ff <= req_octave_select;
      idx_ff  <= req_table_index;
      val_ff  <= req_table_value;
      x_ff    <= req_x_coord;
      y_ff    <= req_y_coord;
   end

   assign wr.en     = valid_ff && (mode_ff == opn_pkg::MODE_LOAD);
   assign wr.octave = osel_ff;
   assign wr.addr   = idx_ff;
   assign wr.data   = val_ff;

   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
      opn_lane #(.FRAC_BITS(FRAC_BITS), .LANE(i)) u_lane (
         .clock(clock), .reset(reset), .wr(wr),
         .x_coord(x_ff), .y_coord(y_ff), .noise(noise[i]));
   end

   opn_sum #(.MAX_OCTAVES(MAX_OCTAVES), .FRAC_BITS(FRAC_BITS)) u_sum (
      .clock(clock), .reset(reset), .in_valid(eval_ff[opn_pkg::LANE_LAT-1]),
      .count(count_ff), .noise(noise), .out_valid(rsp_strobe), .out_sum(rsp_noise_sum));

   `OPN_ASSERT_AFTER(a_eval_gives_rsp, start && !busy && req_mode == opn_pkg::MODE_EVAL, 9, rsp_strobe)
   `OPN_ASSERT_AFTER(a_load_no_rsp, start && !busy && req_mode == opn_pkg::MODE_LOAD, 9, !rsp_strobe)
   `OPN_ASSERT_NOW(a_no_write_on_eval, valid_ff && mode_ff == opn_pkg::MODE_EVAL, !wr.en)
endmodule

FILE: hdl/opn_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module opn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/opn_lane.sv
// One octave of 2D gradient noise: table copies, hash, fade and lerp pipeline.
// Depends on opn_pkg and opn_ram.
`timescale 1ns / 1ps
module opn_lane #(
   parameter int FRAC_BITS = opn_pkg::DEF_FRAC_BITS,
   parameter int LANE      = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  opn_pkg::tbl_wr_type       wr,
   input  logic signed [31:0]        x_coord,
   input  logic signed [31:0]        y_coord,
   output logic signed [FRAC_BITS+5:0] noise
);
   localparam int QW = FRAC_BITS + 6;
   localparam int IW = opn_pkg::IDX_W;
   localparam logic signed [QW-1:0] ONE = QW'(64'sd1 <<< FRAC_BITS);

   function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
      logic signed [2*QW-1:0] p;
      p = a * b;
      return QW'(p >>> FRAC_BITS);
   endfunction

   function automatic logic signed [QW-1:0] gterm(input logic [1:0] c,
                                                  input logic signed [QW-1:0] d);
      logic signed [QW-1:0] r;
      case (c)
         2'd0:    r = -d;
         2'd1:    r = '0;
         2'd2:    r = d;
         default: r = d <<< 1;
      endcase
      return r;
   endfunction

   function automatic logic signed [QW-1:0] gdot(input logic [IW-1:0] h,
                                                 input logic signed [QW-1:0] dx,
                                                 input logic signed [QW-1:0] dy);
      return gterm(opn_pkg::grad_code(h[3:0], opn_pkg::GRAD_X_BITS), dx)
           + gterm(opn_pkg::grad_code(h[3:0], opn_pkg::GRAD_Y_BITS), dy);
   endfunction

   logic signed [31:0] xs, ys;
   logic [IW-1:0] cx;
   logic signed [QW-1:0] t0 [2];

   logic                en1_ff, en2_ff;
   opn_pkg::tbl_wr_type wr1_ff, wr2_ff;
   logic [IW-1:0]       cy1_ff;
   logic signed [QW-1:0] t1_ff [2], tt1_ff [2], m1_ff [2];
   logic signed [QW-1:0] t2_ff [2], cube2_ff [2], inner2_ff [2];
   logic signed [QW-1:0] t3_ff [2], fade3_ff [2];
   logic signed [QW-1:0] g4_ff [4], u4_ff, v4_ff;
   logic signed [QW-1:0] row5_ff [2], v5_ff;
   logic signed [QW-1:0] noise_ff;

   logic [IW-1:0] p1 [2];
   logic [IW-1:0] a2 [4];
   logic [IW-1:0] p2 [4];
   logic [IW-1:0] h3 [4];
   logic wr0_en, wr1_en, wr2_en;

   assign xs = x_coord >>> LANE;
   assign ys = y_coord >>> LANE;
   assign cx = xs[FRAC_BITS +: IW];
   assign t0[0] = QW'({1'b0, xs[FRAC_BITS-1:0]});
   assign t0[1] = QW'({1'b0, ys[FRAC_BITS-1:0]});

   assign wr0_en = wr.en && (int'(wr.octave) == LANE);
   assign wr1_en = en1_ff && (int'(wr1_ff.octave) == LANE);
   assign wr2_en = en2_ff && (int'(wr2_ff.octave) == LANE);

   opn_ram #(.WIDTH(IW), .DEPTH(opn_pkg::TABLE_SIZE)) u_l1_0 (
      .clock(clock), .wr_en(wr0_en), .wr_addr(wr.addr), .wr_data(wr.data),
      .rd_addr(cx), .rd_data(p1[0]));
   opn_ram #(.WIDTH(IW), .DEPTH(opn_pkg::TABLE_SIZE)) u_l1_1 (
      .clock(clock), .wr_en(wr0_en), .wr_addr(wr.addr), .wr_data(wr.data),
      .rd_addr(cx + IW'(1)), .rd_data(p1[1]));

   assign a2[0] = p1[0] + cy1_ff;
   assign a2[1] = p1[0] + cy1_ff + IW'(1);
   assign a2[2] = p1[1] + cy1_ff;
   assign a2[3] = p1[1] + cy1_ff + IW'(1);

   for (genvar k = 0; k < 4; k++) begin : g_tbl
      opn_ram #(.WIDTH(IW), .DEPTH(opn_pkg::TABLE_SIZE)) u_l2 (
         .clock(clock), .wr_en(wr1_en), .wr_addr(wr1_ff.addr), .wr_data(wr1_ff.data),
         .rd_addr(a2[k]), .rd_data(p2[k]));
      opn_ram #(.WIDTH(IW), .DEPTH(opn_pkg::TABLE_SIZE)) u_l3 (
         .clock(clock), .wr_en(wr2_en), .wr_addr(wr2_ff.addr), .wr_data(wr2_ff.data),
         .rd_addr(p2[k]), .rd_data(h3[k]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en1_ff <= 1'b0;
         en2_ff <= 1'b0;
      end else begin
         en1_ff <= wr.en;
         en2_ff <= en1_ff;
      end
      wr1_ff <= wr;
      wr2_ff <= wr1_ff;
      cy1_ff <= ys[FRAC_BITS +: IW];
      for (int k = 0; k < 2; k++) begin
         t1_ff[k]     <= t0[k];
         tt1_ff[k]    <= qmul(t0[k], t0[k]);
         m1_ff[k]     <= qmul(t0[k], t0[k] * QW'(6) - ONE * QW'(15));
         t2_ff[k]     <= t1_ff[k];
         cube2_ff[k]  <= qmul(tt1_ff[k], t1_ff[k]);
         inner2_ff[k] <= m1_ff[k] + ONE * QW'(10);
         t3_ff[k]     <= t2_ff[k];
         fade3_ff[k]  <= qmul(cube2_ff[k], inner2_ff[k]);
      end
      g4_ff[0] <= gdot(h3[0], t3_ff[0], t3_ff[1]);
      g4_ff[1] <= gdot(h3[2], t3_ff[0] - ONE, t3_ff[1]);
      g4_ff[2] <= gdot(h3[1], t3_ff[0], t3_ff[1] - ONE);
      g4_ff[3] <= gdot(h3[3], t3_ff[0] - ONE, t3_ff[1] - ONE);
      u4_ff    <= fade3_ff[0];
      v4_ff    <= fade3_ff[1];
      row5_ff[0] <= g4_ff[0] + qmul(u4_ff, g4_ff[1] - g4_ff[0]);
      row5_ff[1] <= g4_ff[2] + qmul(u4_ff, g4_ff[3] - g4_ff[2]);
      v5_ff      <= v4_ff;
      noise_ff   <= row5_ff[0] + qmul(v5_ff, row5_ff[1] - row5_ff[0]);
   end

   assign noise = noise_ff;
endmodule

FILE: hdl/opn_sum.sv
// Octave weighting, summation and output saturation, two register stages.
// Depends on opn_pkg.
`timescale 1ns / 1ps
module opn_sum #(
   parameter int MAX_OCTAVES = opn_pkg::DEF_MAX_OCTAVES,
   parameter int FRAC_BITS   = opn_pkg::DEF_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [opn_pkg::COUNT_W-1:0]       count,
   input  logic signed [FRAC_BITS+5:0]       noise [MAX_OCTAVES],
   output logic                              out_valid,
   output logic signed [opn_pkg::OUT_W-1:0]  out_sum
);
   localparam int QW = FRAC_BITS + 6;
   localparam int SW = QW + MAX_OCTAVES + 5;
   localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (opn_pkg::OUT_W - 1)) - 1);
   localparam logic signed [SW-1:0] SMIN = SW'(-(64'sd1 <<< (opn_pkg::OUT_W - 1)));

   logic signed [SW-1:0] term_ff [MAX_OCTAVES];
   logic                 va_ff, vb_ff;
   logic signed [opn_pkg::OUT_W-1:0] sum_ff;
   logic signed [SW-1:0] total;
   int                   eff;

   always_comb begin
      eff = (int'(count) > MAX_OCTAVES) ? MAX_OCTAVES : int'(count);
      total = '0;
      for (int i = 0; i < MAX_OCTAVES; i++) begin
         total = total + term_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
      for (int i = 0; i < MAX_OCTAVES; i++) begin
         term_ff[i] <= (i < eff) ? (SW'(noise[i]) <<< i) : '0;
      end
      if (total > SMAX) begin
         sum_ff <= opn_pkg::OUT_W'(SMAX);
      end else if (total < SMIN) begin
         sum_ff <= opn_pkg::OUT_W'(SMIN);
      end else begin
         sum_ff <= opn_pkg::OUT_W'(total);
      end
   end

   assign out_valid = vb_ff;
   assign out_sum   = sum_ff;
endmodule

FILE: tb/octave_perlin_noise_2d_core_test.sv
// Self-checking testbench for octave_perlin_noise_2d_core: loads tables, evaluates noise,
// predicts each octave sum in fixed point and compares every result transfer.
// Depends on opn_pkg and the core RTL only.
`timescale 1ns / 1ps
module octave_perlin_noise_2d_core_test;

   typedef struct {
      logic              mode;
      logic [2:0]        octave;
      logic [7:0]        index;
      logic [7:0]        value;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } noise_req_type;

   localparam longint ONE = 64'sd65536;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_mode = opn_pkg::MODE_LOAD;
   logic [2:0] req_octave_select = '0;
   logic [7:0] req_table_index = '0;
   logic [7:0] req_table_value = '0;
   logic signed [31:0] req_x_coord = '0;
   logic signed [31:0] req_y_coord = '0;
   logic rsp_strobe;
   logic signed [opn_pkg::OUT_W-1:0] rsp_noise_sum;
   logic csr_we = 1'b0;
   logic [opn_pkg::COUNT_W-1:0] csr_wdata = '0;

   noise_req_type pending_reqs[$];
   logic signed [opn_pkg::OUT_W-1:0] sums_due[$];
   logic [7:0] perm_copy[8][256];
   logic [opn_pkg::COUNT_W-1:0] octave_cfg;
   logic taken = 1'b0;
   int gap_left = 0;
   bit no_idle = 1'b0;
   int mismatches = 0;

   octave_perlin_noise_2d_core dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> 16;
   endfunction

   function automatic longint fade_q(longint t);
      longint inner, cube;
      inner = qmul(t, 6 * t - 15 * ONE) + 10 * ONE;
      cube = qmul(qmul(t, t), t);
      return qmul(cube, inner);
   endfunction

   function automatic longint corner_dot(logic [7:0] h, longint dx, longint dy);
      longint gx, gy;
      gx = longint'((opn_pkg::GRAD_X_BITS >> (h[3:0] * 2)) & 32'd3) - 1;
      gy = longint'((opn_pkg::GRAD_Y_BITS >> (h[3:0] * 2)) & 32'd3) - 1;
      return gx * dx + gy * dy;
   endfunction

   function automatic longint octave_value(int o, longint xs, longint ys);
      logic [7:0] cx, cy, a, b;
      longint fx, fy, u, v, g00, g10, g01, g11, r0, r1;
      cx = xs[23:16];
      cy = ys[23:16];
      fx = longint'({48'd0, xs[15:0]});
      fy = longint'({48'd0, ys[15:0]});
      u = fade_q(fx);
      v = fade_q(fy);
      a = perm_copy[o][cx] + cy;
      b = perm_copy[o][8'(cx + 1)] + cy;
      g00 = corner_dot(perm_copy[o][perm_copy[o][a]], fx, fy);
      g10 = corner_dot(perm_copy[o][perm_copy[o][b]], fx - ONE, fy);
      g01 = corner_dot(perm_copy[o][perm_copy[o][8'(a + 1)]], fx, fy - ONE);
      g11 = corner_dot(perm_copy[o][perm_copy[o][8'(b + 1)]], fx - ONE, fy - ONE);
      r0 = g00 + qmul(u, g10 - g00);
      r1 = g01 + qmul(u, g11 - g01);
      return r0 + qmul(v, r1 - r0);
   endfunction

   function automatic logic signed [opn_pkg::OUT_W-1:0] predict_noise_sum(longint x, longint y);
      longint sum;
      int n;
      sum = 0;
      n = (octave_cfg > 8) ? 8 : int'(octave_cfg);
      for (int i = 0; i < n; i++)
         sum += octave_value(i, x >>> i, y >>> i) <<< i;
      if (sum > 64'sd33554431) sum = 64'sd33554431;
      if (sum < -64'sd33554432) sum = -64'sd33554432;
      return sum[opn_pkg::OUT_W-1:0];
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset && !(start && !taken)) begin
         if (gap_left > 0 || pending_reqs.size() == 0) begin
            start <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            noise_req_type r;
            r = pending_reqs.pop_front();
            start <= 1'b1;
            req_mode <= r.mode;
            req_octave_select <= r.octave;
            req_table_index <= r.index;
            req_table_value <= r.value;
            req_x_coord <= r.x;
            req_y_coord <= r.y;
            if ($urandom_range(0, 99) < 3) no_idle = !no_idle;
            gap_left <= no_idle ? 0 : int'($urandom_range(0, 18));
         end
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      logic signed [opn_pkg::OUT_W-1:0] want;
      if (reset) begin
         octave_cfg = opn_pkg::COUNT_RESET;
         taken <= 1'b0;
      end else begin
         if (csr_we) octave_cfg = csr_wdata;
         taken <= start && !busy;
         if (start && !busy) begin
            if (req_mode == opn_pkg::MODE_LOAD)
               perm_copy[req_octave_select][req_table_index] = req_table_value;
            else
               sums_due.push_back(predict_noise_sum(req_x_coord, req_y_coord));
         end
         if (rsp_strobe) begin
            if (sums_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %0d", rsp_noise_sum);
            end else begin
               want = sums_due.pop_front();
               if (want !== rsp_noise_sum) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("noise_sum mismatch: expected %0d, got %0d", want, rsp_noise_sum);
               end
            end
         end
      end
   end

   function automatic noise_req_type load_req(logic [2:0] o, logic [7:0] i, logic [7:0] v);
      noise_req_type r;
      r.mode = opn_pkg::MODE_LOAD;
      r.octave = o;
      r.index = i;
      r.value = v;
      r.x = $urandom;
      r.y = $urandom;
      return r;
   endfunction

   function automatic noise_req_type eval_req(logic [31:0] x, logic [31:0] y);
      noise_req_type r;
      r.mode = opn_pkg::MODE_EVAL;
      r.octave = 3'($urandom);
      r.index = 8'($urandom);
      r.value = 8'($urandom);
      r.x = x;
      r.y = y;
      return r;
   endfunction

   task automatic drain();
      while (pending_reqs.size() != 0 || start || sums_due.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_count(logic [opn_pkg::COUNT_W-1:0] c);
      drain();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= c;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_items(int n);
      logic [31:0] x, y;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) < 2) begin
            pending_reqs.push_back(load_req(3'($urandom_range(0, 7)),
                                            8'($urandom_range(0, 255)),
                                            8'($urandom_range(0, 255))));
         end else begin
            x = $urandom;
            y = $urandom;
            if ($urandom_range(0, 1)) begin
               x = $signed(x) >>> $urandom_range(4, 28);
               y = $signed(y) >>> $urandom_range(4, 28);
            end
            pending_reqs.push_back(eval_req(x, y));
         end
      end
   endtask

   initial begin
      logic [opn_pkg::COUNT_W-1:0] counts[6];
      counts = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd3, 4'd0};
      counts[5] = opn_pkg::COUNT_W'($urandom_range(1, 7));
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // every table entry written before any evaluate reads it
      for (int o = 0; o < 8; o++)
         for (int i = 0; i < 256; i++)
            pending_reqs.push_back(load_req(3'(o), 8'(i), 8'($urandom_range(0, 255))));
      pending_reqs.push_back(load_req(3'd7, 8'd255, 8'd255));
      pending_reqs.push_back(load_req(3'd0, 8'd0, 8'd0));
      pending_reqs.push_back(eval_req(32'h0000_0000, 32'h0000_0000));
      pending_reqs.push_back(eval_req(32'h7FFF_FFFF, 32'h7FFF_FFFF));
      pending_reqs.push_back(eval_req(32'h8000_0000, 32'h8000_0000));
      pending_reqs.push_back(eval_req(32'hFFFF_FFFF, 32'h0000_FFFF));
      pending_reqs.push_back(eval_req(32'h0001_0000, 32'hFFFF_0000));
      pending_reqs.push_back(eval_req(32'h8000_0000, 32'h7FFF_FFFF));
      pending_reqs.push_back(eval_req(32'h0000_8000, 32'hFFFF_8000));
      pending_reqs.push_back(eval_req(32'h00FF_FFFF, 32'hFF00_0001));
      pending_reqs.push_back(eval_req(32'h5555_5555, 32'hAAAA_AAAA));
      random_items(150);
      foreach (counts[j]) begin
         write_count(counts[j]);
         pending_reqs.push_back(eval_req(32'h7FFF_FFFF, 32'h8000_0000));
         random_items(175);
      end
      drain();
      if (mismatches == 0 && sums_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
